// ===== rtl/tct_pkg.sv =====
`timescale 1ns / 1ps

package tct_pkg;

  // button event codes on the result channel
  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_PRESS   = 2'd1,
    EV_RELEASE = 2'd2
  } button_event_e;

  // configuration register indexes
  localparam int CFG_ADDR_BITS = 2;
  localparam logic [CFG_ADDR_BITS-1:0] REG_CENTER = 2'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_HEIGHT = 2'd2;

  // reset values
  localparam int REST_MIN     = 400;
  localparam int REST_MAX     = 700;
  localparam int CENTER_RESET = REST_MIN / 2 + REST_MAX / 2;
  localparam int POS_START    = 350;
  localparam int WIDTH_RESET  = 1024;
  localparam int HEIGHT_RESET = 768;

  // divide by ten through a reciprocal, exact for any 16 bit dividend
  localparam int DIV_IN_BITS = 16;
  localparam int PROD_BITS   = 2 * DIV_IN_BITS;
  localparam int DIV10_MUL   = 52429;
  localparam int DIV10_SHIFT = 19;

  // quotients up to this value give a step of -1, 0 or 1
  localparam int DEAD_Q_MAX = 2;

  localparam int AXES   = 2;
  localparam int AXIS_X = 0;
  localparam int AXIS_Y = 1;

endpackage

// ===== rtl/tct_if.sv =====
`timescale 1ns / 1ps

interface tct_in_if #(
  parameter int SAMPLE_BITS = 10
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] tilt_x;
  logic [SAMPLE_BITS-1:0] tilt_y;
  logic                   button_level;

  modport source (output valid, output tilt_x, output tilt_y, output button_level,
                  input ready);
  modport sink (input valid, input tilt_x, input tilt_y, input button_level,
                output ready);
endinterface

interface tct_out_if #(
  parameter int COORD_BITS = 13
);
  logic                   valid;
  logic                   ready;
  logic [COORD_BITS-1:0]  cursor_x;
  logic [COORD_BITS-1:0]  cursor_y;
  tct_pkg::button_event_e button_event;

  modport source (output valid, output cursor_x, output cursor_y, output button_event,
                  input ready);
  modport sink (input valid, input cursor_x, input cursor_y, input button_event,
                output ready);
endinterface

// ===== rtl/tilt_to_cursor_tracker_core.sv =====
`timescale 1ns / 1ps

// path: an input transaction is registered in stage one, then in the output register (two stages)
// throughput: one transaction per cycle while results drain; a stalled result lets one
// more transaction into stage one, then in_ch.ready stays low until the result leaves
// the position feedback closes inside the update stage, so back-to-back samples chain cleanly
// reset: rst_ni asynchronous active low; empties both stages, position 350/350,
// button level unknown, registers center 550, width 1024, height 768 (masked to width)
module tilt_to_cursor_tracker_core #(
  parameter int SAMPLE_BITS = 10,
  parameter int COORD_BITS  = 13
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        cfg_we_i,
  input  logic [tct_pkg::CFG_ADDR_BITS-1:0]           cfg_addr_i,
  input  logic [((SAMPLE_BITS > COORD_BITS) ? SAMPLE_BITS : COORD_BITS)-1:0] cfg_wdata_i,
  tct_in_if.sink                                      in_ch,
  tct_out_if.source                                   out_ch
);
  import tct_pkg::*;

  // quotient width: a sample distance below 2^SAMPLE_BITS over ten
  localparam int QW = SAMPLE_BITS - 3;
  // signed width for the position sum, room for carry and sign
  localparam int AW = ((SAMPLE_BITS > COORD_BITS) ? SAMPLE_BITS : COORD_BITS) + 2;

  localparam logic [SAMPLE_BITS-1:0] CenterRst = SAMPLE_BITS'(CENTER_RESET);
  localparam logic [COORD_BITS-1:0]  WidthRst  = COORD_BITS'(WIDTH_RESET);
  localparam logic [COORD_BITS-1:0]  HeightRst = COORD_BITS'(HEIGHT_RESET);
  localparam logic [COORD_BITS-1:0]  PosRst    = COORD_BITS'(POS_START);

  // configuration registers
  logic [SAMPLE_BITS-1:0] center_q;
  logic [COORD_BITS-1:0]  width_q;
  logic [COORD_BITS-1:0]  height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q <= CenterRst;
      width_q  <= WidthRst;
      height_q <= HeightRst;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_CENTER: center_q <= cfg_wdata_i[SAMPLE_BITS-1:0];
        REG_WIDTH:  width_q  <= cfg_wdata_i[COORD_BITS-1:0];
        REG_HEIGHT: height_q <= cfg_wdata_i[COORD_BITS-1:0];
        default: ;  // index beyond the register list is dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // handshake: two stages with valid bits; the output register is the second
  // stage, so an input transaction is taken whenever stage one will be empty
  // or is moving on
  // ---------------------------------------------------------------------------
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;
  logic advance;  // update stage may load
  logic load1;    // input transaction into stage one
  logic load2;    // stage one into the output register

  always_comb begin
    advance     = !out_valid_q || out_ch.ready;
    in_ch.ready = !s1_valid_q || advance;
    load1       = in_ch.valid && in_ch.ready;
    load2       = s1_valid_q && advance;
    s1_valid_d  = load1 || (s1_valid_q && !advance);
    out_valid_d = load2 || (out_valid_q && !out_ch.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // ---------------------------------------------------------------------------
  // stage one: distance from center and step size per axis
  // the step is distance/10 - 1; a quotient of 0..2 is the dead zone unless
  // the sample sits exactly on center, which still goes through the clamp
  // ---------------------------------------------------------------------------
  logic [SAMPLE_BITS-1:0] smp   [AXES];
  logic [SAMPLE_BITS-1:0] delta [AXES];
  logic [PROD_BITS-1:0]   prod  [AXES];
  logic [QW-1:0]          quo   [AXES];
  logic                   up_d   [AXES];
  logic                   keep_d [AXES];
  logic [QW-1:0]          mag_d  [AXES];

  always_comb begin
    smp[AXIS_X] = in_ch.tilt_x;
    smp[AXIS_Y] = in_ch.tilt_y;
    for (int a = 0; a < AXES; a++) begin
      up_d[a]   = smp[a] > center_q;
      delta[a]  = up_d[a] ? (smp[a] - center_q) : (center_q - smp[a]);
      // reciprocal multiply replaces the divide by ten
      prod[a]   = PROD_BITS'(DIV_IN_BITS'(delta[a])) * PROD_BITS'(DIV10_MUL);
      quo[a]    = prod[a][DIV10_SHIFT +: QW];
      keep_d[a] = (delta[a] != '0) && (quo[a] <= QW'(DEAD_Q_MAX));
      mag_d[a]  = (delta[a] != '0 && !keep_d[a]) ? (quo[a] - QW'(1)) : '0;
    end
  end

  logic          up_q   [AXES];
  logic          keep_q [AXES];
  logic [QW-1:0] mag_q  [AXES];
  logic          lvl_q;

  always_ff @(posedge clk_i) begin
    if (load1) begin
      for (int a = 0; a < AXES; a++) begin
        up_q[a]   <= up_d[a];
        keep_q[a] <= keep_d[a];
        mag_q[a]  <= mag_d[a];
      end
      lvl_q <= in_ch.button_level;
    end
  end

  // ---------------------------------------------------------------------------
  // stage two: move, clamp, button edge detect
  // x runs against the tilt (sample above center lowers it), y runs with it;
  // a dead-zone axis keeps its position untouched, even above a lowered limit
  // ---------------------------------------------------------------------------
  logic [COORD_BITS-1:0] pos_q [AXES];
  logic [COORD_BITS-1:0] pos_d [AXES];
  logic [COORD_BITS-1:0] limit [AXES];
  logic signed [AW-1:0]  sum   [AXES];
  logic                  lower [AXES];
  logic                  known_q;
  logic                  last_q;
  button_event_e         ev_d;

  always_comb begin
    limit[AXIS_X] = width_q;
    limit[AXIS_Y] = height_q;
    for (int a = 0; a < AXES; a++) begin
      lower[a] = (a == AXIS_X) ? up_q[a] : !up_q[a];
      sum[a]   = lower[a] ? (AW'(pos_q[a]) - AW'(mag_q[a]))
                          : (AW'(pos_q[a]) + AW'(mag_q[a]));
      if (keep_q[a]) begin
        pos_d[a] = pos_q[a];
      end else if (sum[a] > $signed(AW'(limit[a]))) begin
        pos_d[a] = limit[a];
      end else if (sum[a] < 0) begin
        pos_d[a] = '0;
      end else begin
        pos_d[a] = sum[a][COORD_BITS-1:0];
      end
    end

    // first sample after reset always reports its level
    if (!known_q || lvl_q != last_q) begin
      ev_d = lvl_q ? EV_PRESS : EV_RELEASE;
    end else begin
      ev_d = EV_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < AXES; a++) begin
        pos_q[a] <= PosRst;
      end
      known_q <= 1'b0;
      last_q  <= 1'b0;
    end else if (load2) begin
      for (int a = 0; a < AXES; a++) begin
        pos_q[a] <= pos_d[a];
      end
      known_q <= 1'b1;
      last_q  <= lvl_q;
    end
  end

  // output register payload
  logic [COORD_BITS-1:0] cursor_x_q;
  logic [COORD_BITS-1:0] cursor_y_q;
  button_event_e         event_q;

  always_ff @(posedge clk_i) begin
    if (load2) begin
      cursor_x_q <= pos_d[AXIS_X];
      cursor_y_q <= pos_d[AXIS_Y];
      event_q    <= ev_d;
    end
  end

  assign out_ch.valid        = out_valid_q;
  assign out_ch.cursor_x     = cursor_x_q;
  assign out_ch.cursor_y     = cursor_y_q;
  assign out_ch.button_event = event_q;

endmodule

// ===== rtl/tct_checker.sv =====
`timescale 1ns / 1ps

module tct_checker #(
  parameter int COORD_BITS = 13
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_i,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input logic [COORD_BITS-1:0] cursor_x_i,
  input logic [COORD_BITS-1:0] cursor_y_i,
  input logic [1:0]            button_event_i
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(cursor_x_i) &&
                                    $stable(cursor_y_i) && $stable(button_event_i))
    else $error("result changed while stalled");

  // input side only backs off when the output register is full and stalled
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input not ready without output stall");

  // an accepted sample reaches the output register through stage one when the sink keeps draining
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) ##1 (!out_valid_i || out_ready_i) |=> out_valid_i)
    else $error("accepted sample produced no result");

endmodule

bind tilt_to_cursor_tracker_core tct_checker #(
  .COORD_BITS(COORD_BITS)
) u_tct_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_ch.valid),
  .in_ready_i    (in_ch.ready),
  .out_valid_i   (out_ch.valid),
  .out_ready_i   (out_ch.ready),
  .cursor_x_i    (out_ch.cursor_x),
  .cursor_y_i    (out_ch.cursor_y),
  .button_event_i(out_ch.button_event)
);

// ===== tb/sv/tct_tracker_checker.sv =====
`timescale 1ns / 1ps

module tct_tracker_checker #(
  parameter int SAMPLE_BITS = 10,
  parameter int COORD_BITS  = 13,
  parameter int CFG_BITS    = (SAMPLE_BITS > COORD_BITS) ? SAMPLE_BITS : COORD_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tct_pkg::CFG_ADDR_BITS-1:0] cfg_addr_i,
  input  logic [CFG_BITS-1:0]               cfg_wdata_i,
  tct_in_if                                 in_mon,
  tct_out_if                                out_mon,
  output int                                err_count_o,
  output int                                pending_o,
  output int                                checked_o
);
  import tct_pkg::*;

  localparam int TILT_STEP_DIV = 10;
  localparam int REPORT_MAX    = 20;

  typedef struct packed {
    logic [COORD_BITS-1:0] cursor_x;
    logic [COORD_BITS-1:0] cursor_y;
    button_event_e         button_event;
  } cursor_update_t;

  cursor_update_t expected_updates_q[$];

  logic [SAMPLE_BITS-1:0] center_lvl;
  logic [COORD_BITS-1:0]  max_x;
  logic [COORD_BITS-1:0]  max_y;
  logic [COORD_BITS-1:0]  pos_x;
  logic [COORD_BITS-1:0]  pos_y;
  logic                   last_level;
  logic                   level_seen;
  int                     mismatches;
  int                     compared;

  // new axis position; follows_tilt is set when a sample above center raises it
  function automatic logic [COORD_BITS-1:0] track_axis(input logic [COORD_BITS-1:0]  pos,
                                                       input logic [SAMPLE_BITS-1:0] sample,
                                                       input logic [SAMPLE_BITS-1:0] center,
                                                       input logic [COORD_BITS-1:0]  limit,
                                                       input bit                     follows_tilt);
    int p;
    int s;
    int c;
    int delta;
    int step;
    p = int'(pos);
    s = int'(sample);
    c = int'(center);
    if (s != c) begin
      delta = (s > c) ? s - c : c - s;
      step = delta / TILT_STEP_DIV - 1;
      // dead zone, kept as is and not clamped
      if (step <= 1) return pos;
      if (s < c) step = -step;
      p = follows_tilt ? p + step : p - step;
    end
    if (p > int'(limit)) p = int'(limit);
    if (p < 0) p = 0;
    return p[COORD_BITS-1:0];
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= REPORT_MAX)
      $display("%0t ns: %s got %0d expected %0d", $time, what, got, want);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    cursor_update_t want;
    if (!rst_ni) begin
      center_lvl = SAMPLE_BITS'(CENTER_RESET);
      max_x      = COORD_BITS'(WIDTH_RESET);
      max_y      = COORD_BITS'(HEIGHT_RESET);
      pos_x      = COORD_BITS'(POS_START);
      pos_y      = COORD_BITS'(POS_START);
      last_level = 1'b0;
      level_seen = 1'b0;
      mismatches = 0;
      compared   = 0;
      expected_updates_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_CENTER: center_lvl = cfg_wdata_i[SAMPLE_BITS-1:0];
          REG_WIDTH:  max_x = cfg_wdata_i[COORD_BITS-1:0];
          REG_HEIGHT: max_y = cfg_wdata_i[COORD_BITS-1:0];
          default: ;
        endcase
      end

      if (out_mon.valid && out_mon.ready) begin
        if (expected_updates_q.size() == 0) begin
          report_mismatch("unexpected result transaction, cursor_x", int'(out_mon.cursor_x), -1);
        end else begin
          want = expected_updates_q.pop_front();
          compared++;
          if (out_mon.cursor_x !== want.cursor_x)
            report_mismatch("cursor_x", int'(out_mon.cursor_x), int'(want.cursor_x));
          if (out_mon.cursor_y !== want.cursor_y)
            report_mismatch("cursor_y", int'(out_mon.cursor_y), int'(want.cursor_y));
          if (out_mon.button_event !== want.button_event)
            report_mismatch("button_event", int'(out_mon.button_event),
                            int'(want.button_event));
        end
      end

      if (in_mon.valid && in_mon.ready) begin
        pos_x = track_axis(pos_x, in_mon.tilt_x, center_lvl, max_x, 1'b0);
        pos_y = track_axis(pos_y, in_mon.tilt_y, center_lvl, max_y, 1'b1);
        want.cursor_x = pos_x;
        want.cursor_y = pos_y;
        if (!level_seen || in_mon.button_level != last_level) begin
          want.button_event = in_mon.button_level ? EV_PRESS : EV_RELEASE;
          last_level = in_mon.button_level;
          level_seen = 1'b1;
        end else begin
          want.button_event = EV_NONE;
        end
        expected_updates_q.push_back(want);
      end
    end
    err_count_o <= mismatches;
    pending_o   <= expected_updates_q.size();
    checked_o   <= compared;
  end

endmodule

// ===== tb/sv/tb_tilt_to_cursor_tracker_core.sv =====
`timescale 1ns / 1ps

module tb_tilt_to_cursor_tracker_core;
  import tct_pkg::*;

  localparam int SAMPLE_BITS = 10;
  localparam int COORD_BITS  = 13;
  localparam int CFG_BITS    = (SAMPLE_BITS > COORD_BITS) ? SAMPLE_BITS : COORD_BITS;
  localparam int SAMPLE_MAX  = (1 << SAMPLE_BITS) - 1;
  localparam int COORD_MAX   = (1 << COORD_BITS) - 1;
  localparam int CFG_MAX     = (1 << CFG_BITS) - 1;

  // index past the last register, writes there must be ignored
  localparam logic [CFG_ADDR_BITS-1:0] REG_SPARE = 2'd3;

  // two pipeline stages plus some margin
  localparam int LATENCY_CYCLES = 4;
  // long receiver hold-off that backs the pipe up into the input
  localparam int HOLD_CYCLES    = 64;
  // cycles without any transaction before the run is declared hung
  localparam int WATCHDOG_LIMIT = 2000;
  // samples that push both axes toward the far screen edge
  localparam int DIRECTED_CLIMB = 12;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [CFG_ADDR_BITS-1:0] cfg_addr_i;
  logic [CFG_BITS-1:0]      cfg_wdata_i;

  tct_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) in_ch ();
  tct_out_if #(.COORD_BITS(COORD_BITS))   out_ch ();

  int err_count;
  int pending;
  int checked;

  int                     items_sent;
  int                     settings_applied;
  int                     send_run_left;
  bit                     steady_send;
  bit                     hold_req;
  logic [SAMPLE_BITS-1:0] cur_center;
  logic                   level;

  tilt_to_cursor_tracker_core #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .COORD_BITS (COORD_BITS)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  // watches both channels and the register port, predicts and compares
  tct_tracker_checker #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .COORD_BITS (COORD_BITS)
  ) u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .err_count_o(err_count),
    .pending_o  (pending),
    .checked_o  (checked)
  );

  // 2 ns period
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // idle length: mostly from the short range, now and then from the long one
  function automatic int pick_idle();
    if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // sample a few counts off center, folded back if it falls outside the range
  function automatic logic [SAMPLE_BITS-1:0] beside_center(input logic [SAMPLE_BITS-1:0] c,
                                                           input int off);
    int v;
    v = int'(c) + off;
    if (v < 0 || v > SAMPLE_MAX) v = int'(c) - off;
    return SAMPLE_BITS'(v);
  endfunction

  // random sample weighted toward center so dead zone edges get hit often
  function automatic logic [SAMPLE_BITS-1:0] random_sample(input logic [SAMPLE_BITS-1:0] c);
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 10) return c;
    if (r < 40) begin
      v = int'(c) + int'($urandom_range(0, 70)) - 35;
      if (v < 0) v = 0;
      if (v > SAMPLE_MAX) v = SAMPLE_MAX;
      return SAMPLE_BITS'(v);
    end
    return SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
  endfunction

  // screen size, half the time small enough that clamping is frequent
  function automatic logic [CFG_BITS-1:0] random_span();
    if ($urandom_range(0, 1) == 0) return CFG_BITS'($urandom_range(0, 200));
    return CFG_BITS'($urandom_range(0, COORD_MAX));
  endfunction

  // offer one sample, after an optional idle gap, and wait until it is taken
  task automatic send_sample(input logic [SAMPLE_BITS-1:0] x, input logic [SAMPLE_BITS-1:0] y,
                             input logic b);
    int gap;
    gap = 0;
    if (!steady_send) begin
      if (send_run_left > 0) begin
        send_run_left--;
      end else begin
        gap = pick_idle();
        send_run_left = $urandom_range(0, 24);
      end
    end
    @(negedge clk_i);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.tilt_x       <= x;
    in_ch.tilt_y       <= y;
    in_ch.button_level <= b;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] idx, input logic [CFG_BITS-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // stop offering and wait until every cursor update has come back
  task automatic drain();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY_CYCLES) @(posedge clk_i);
  endtask

  // new register setting, then a dead zone pair, a center hit and random samples
  task automatic run_phase(input logic [CFG_BITS-1:0] center_word,
                           input logic [CFG_BITS-1:0] width_word,
                           input logic [CFG_BITS-1:0] height_word,
                           input int count, input bit stall_sink, input bit poke_spare);
    drain();
    if (poke_spare) write_reg(REG_SPARE, CFG_BITS'($urandom_range(0, CFG_MAX)));
    write_reg(REG_CENTER, center_word);
    write_reg(REG_WIDTH, width_word);
    write_reg(REG_HEIGHT, height_word);
    cur_center = center_word[SAMPLE_BITS-1:0];
    settings_applied++;
    // receiver holds off while the sender keeps going at full rate
    if (stall_sink) begin
      hold_req    = 1'b1;
      steady_send = 1'b1;
    end
    // dead zone after a size change keeps an out-of-range position, a center hit clamps it
    send_sample(beside_center(cur_center, 5), beside_center(cur_center, -5), level);
    send_sample(cur_center, cur_center, level);
    repeat (count) begin
      if ($urandom_range(0, 99) < 30) level = ~level;
      send_sample(random_sample(cur_center), random_sample(cur_center), level);
    end
    steady_send = 1'b0;
  endtask

  // result side: ready in runs, random stalls, one long hold-off on request
  initial begin : result_sink
    int span;
    out_ch.ready = 1'b0;
    @(negedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else begin
        span = $urandom_range(1, 40);
        out_ch.ready <= 1'b1;
        repeat (span) @(negedge clk_i);
        span = pick_idle();
        out_ch.ready <= 1'b0;
        repeat (span) @(negedge clk_i);
      end
    end
  end

  // ends a hung run: no transaction on either channel for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_addr_i         = '0;
    cfg_wdata_i        = '0;
    in_ch.valid        = 1'b0;
    in_ch.tilt_x       = '0;
    in_ch.tilt_y       = '0;
    in_ch.button_level = 1'b0;
    items_sent         = 0;
    settings_applied   = 1;
    send_run_left      = 0;
    steady_send        = 1'b0;
    hold_req           = 1'b0;
    cur_center         = SAMPLE_BITS'(CENTER_RESET);
    level              = 1'b0;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed part under reset settings
    // first sample always reports its level, a center hit only clamps
    send_sample(cur_center, cur_center, 1'b0);
    send_sample(cur_center, cur_center, 1'b1);
    send_sample(cur_center, cur_center, 1'b1);
    // last distance inside the dead zone, then the first that moves, both sides
    send_sample(beside_center(cur_center, 29), beside_center(cur_center, -29), 1'b0);
    send_sample(beside_center(cur_center, 30), beside_center(cur_center, -30), 1'b0);
    send_sample(beside_center(cur_center, -30), beside_center(cur_center, 30), 1'b1);
    // steps of -1, 0 and 1 all leave the position alone
    send_sample(beside_center(cur_center, 1), beside_center(cur_center, -1), 1'b1);
    send_sample(beside_center(cur_center, 10), beside_center(cur_center, -19), 1'b0);
    send_sample(beside_center(cur_center, 25), beside_center(cur_center, -20), 1'b0);
    // full scale both ways
    send_sample(SAMPLE_BITS'(SAMPLE_MAX), SAMPLE_BITS'(SAMPLE_MAX), 1'b1);
    send_sample('0, '0, 1'b0);
    // x opposite to tilt, y with it: both climb toward the screen edge, y runs into it and clamps
    level = 1'b0;
    repeat (DIRECTED_CLIMB) begin
      level = ~level;
      send_sample('0, SAMPLE_BITS'(SAMPLE_MAX), level);
    end

    // zero screen size with center at the bottom of the range
    run_phase('0, '0, '0, 120, 1'b0, 1'b0);
    // largest screen, center at the top, with the long receiver hold-off
    run_phase(CFG_BITS'(SAMPLE_MAX), CFG_BITS'(COORD_MAX), CFG_BITS'(COORD_MAX), 220,
              1'b1, 1'b0);
    // center written with bits above its width, small screen, spare index poked
    run_phase(CFG_BITS'(13'h1C00 | 13'd612), CFG_BITS'(60), CFG_BITS'(45), 200, 1'b0, 1'b1);
    for (int i = 0; i < 5; i++) begin
      run_phase(CFG_BITS'($urandom_range(0, CFG_MAX)), random_span(), random_span(), 200,
                1'b0, 1'b0);
    end

    drain();
    @(negedge clk_i);
    $display("summary: %0d samples over %0d register settings, %0d cursor updates compared",
             items_sent, settings_applied, checked);
    $display("summary: dead zone edges, center hits, clamps at zero and at the screen edge,");
    $display("summary: wide and ignored register writes, a long result stall");
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/tct_pkg.sv
rtl/tct_if.sv
rtl/tilt_to_cursor_tracker_core.sv
rtl/tct_checker.sv
tb/sv/tct_tracker_checker.sv
tb/sv/tb_tilt_to_cursor_tracker_core.sv
